// ===== hdl/vcfr_pkg.sv =====
`default_nettype none
package vcfr_pkg;

    // Frame bytes and CRC polynomial.
    localparam logic [7:0] SYNC_BYTE1 = 8'hAA;
    localparam logic [7:0] SYNC_BYTE2 = 8'h55;
    localparam logic [7:0] PAD_BYTE   = 8'h00;
    localparam logic [7:0] CRC_POLY   = 8'hD5;

    // Host command codes (command byte shifted right by one).
    localparam logic [6:0] CMD_GET_SETTINGS    = 7'd1;
    localparam logic [6:0] CMD_SET_POWER       = 7'd2;
    localparam logic [6:0] CMD_SET_CHANNEL     = 7'd3;
    localparam logic [6:0] CMD_SET_FREQUENCY   = 7'd4;
    localparam logic [6:0] CMD_SET_MODE        = 7'd5;
    localparam logic [6:0] CMD_GET_SETTINGS_V2 = 7'd9;

    // Protocol version that enables mode commands.
    localparam logic [1:0] VERSION_2     = 2'd2;
    localparam logic [1:0] VERSION_RESET = 2'd1;

    // Register map.
    localparam int unsigned PADDR_W        = 3;
    localparam logic [PADDR_W-1:0] ADDR_VERSION = 3'd0;

    // Settings after reset.
    localparam logic [7:0]  POWER_RESET   = 8'd0;
    localparam logic [7:0]  CHANNEL_RESET = 8'd0;
    localparam logic [7:0]  MODE_RESET    = 8'd1;
    localparam logic [7:0]  MODE_V1_SET   = 8'd1;
    localparam logic [15:0] FREQ_RESET    = 16'd5865;

    // Payload lengths of the replies.
    localparam logic [2:0] PLEN_SETTINGS = 3'd5;
    localparam logic [2:0] PLEN_ONE      = 3'd1;
    localparam logic [2:0] PLEN_FREQ     = 3'd2;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_CMD   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } t_rx_beat;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_last;
    } t_tx_beat;

    // One queued reply: code, payload length and a snapshot of the payload.
    typedef struct packed {
        logic [7:0]      code;
        logic [2:0]      plen;
        logic [4:0][7:0] payload;
    } t_reply;

    // CRC-8, MSB first, one byte.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/vcfr_front.sv =====
`default_nettype none
module vcfr_front
    import vcfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_rx_beat   i_beat,
    input  wire logic [1:0] i_version,
    output logic            o_push,
    output t_reply          o_reply
);

    t_phase      r_phase, n_phase;
    logic [6:0]  r_cmd, n_cmd;
    logic [7:0]  r_left, n_left;
    logic [1:0]  r_index, n_index;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [7:0]  r_power, n_power;
    logic [7:0]  r_channel, n_channel;
    logic [7:0]  r_mode, n_mode;
    logic [15:0] r_freq, n_freq;
    logic        r_done, n_done;

    logic [7:0] b;
    logic       v2;
    logic       frame_ok;
    logic       has_reply;

    assign b  = i_beat.rx_byte;
    assign v2 = (i_version == VERSION_2);

    // A frame completes when the CRC byte matches the running CRC.
    assign frame_ok = i_accept && !r_done && (r_phase == PH_CRC) && (b == r_crc);

    // Next parser phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (!r_done) begin
                unique case (r_phase)
                    PH_SYNC2: begin
                        if (b == SYNC_BYTE2) begin
                            n_phase = PH_CMD;
                        end else if (b == SYNC_BYTE1) begin
                            n_phase = PH_SYNC2;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_CMD: begin
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_phase = (b != 8'd0) ? PH_DATA : PH_CRC;
                    end
                    PH_DATA: begin
                        if (r_left == 8'd1) begin
                            n_phase = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        n_phase = PH_HUNT;
                    end
                    default: begin
                        n_phase = (b == SYNC_BYTE1) ? PH_SYNC2 : PH_HUNT;
                    end
                endcase
            end
            if (i_beat.buffer_end) begin
                n_phase = PH_HUNT;
            end
        end
    end

    // Parser datapath: CRC, command, length and held data bytes.
    always_comb begin
        n_cmd   = r_cmd;
        n_left  = r_left;
        n_index = r_index;
        n_crc   = r_crc;
        n_held0 = r_held0;
        n_held1 = r_held1;
        if (i_accept && !r_done) begin
            unique case (r_phase)
                PH_SYNC2: begin
                    if (b == SYNC_BYTE2) begin
                        n_crc = crc8_update(r_crc, b);
                    end else if (b == SYNC_BYTE1) begin
                        n_crc = crc8_update(8'd0, b);
                    end
                end
                PH_CMD: begin
                    n_cmd   = b[7:1];
                    n_held0 = 8'd0;
                    n_held1 = 8'd0;
                    n_crc   = crc8_update(r_crc, b);
                end
                PH_LEN: begin
                    n_left  = b;
                    n_index = 2'd0;
                    n_crc   = crc8_update(r_crc, b);
                end
                PH_DATA: begin
                    if (r_index == 2'd0) begin
                        n_held0 = b;
                    end else if (r_index == 2'd1) begin
                        n_held1 = b;
                    end
                    // The index saturates; only the first two bytes are kept.
                    if (r_index != 2'd2) begin
                        n_index = r_index + 2'd1;
                    end
                    n_left = r_left - 8'd1;
                    n_crc  = crc8_update(r_crc, b);
                end
                PH_CRC: begin
                end
                default: begin
                    if (b == SYNC_BYTE1) begin
                        n_crc = crc8_update(8'd0, b);
                    end
                end
            endcase
        end
    end

    // Settings update on a good frame, and the reply built from the new values.
    always_comb begin
        n_power   = r_power;
        n_channel = r_channel;
        n_mode    = r_mode;
        n_freq    = r_freq;
        if (frame_ok) begin
            unique case (r_cmd)
                CMD_SET_POWER:     n_power   = r_held0;
                CMD_SET_CHANNEL:   n_channel = r_held0;
                CMD_SET_FREQUENCY: n_freq    = {r_held0, r_held1};
                CMD_SET_MODE:      n_mode    = v2 ? r_held0 : MODE_V1_SET;
                default: begin
                end
            endcase
        end

        has_reply       = 1'b1;
        o_reply.code    = {1'b0, r_cmd};
        o_reply.plen    = PLEN_ONE;
        o_reply.payload = '0;
        unique case (r_cmd) inside
            CMD_GET_SETTINGS, CMD_GET_SETTINGS_V2: begin
                if (r_cmd == CMD_GET_SETTINGS && v2) begin
                    o_reply.code = {1'b0, CMD_GET_SETTINGS_V2};
                end
                o_reply.plen       = PLEN_SETTINGS;
                o_reply.payload[0] = n_channel;
                o_reply.payload[1] = n_power;
                o_reply.payload[2] = n_mode;
                o_reply.payload[3] = n_freq[15:8];
                o_reply.payload[4] = n_freq[7:0];
            end
            CMD_SET_POWER: begin
                o_reply.payload[0] = n_power;
            end
            CMD_SET_CHANNEL: begin
                o_reply.payload[0] = n_channel;
            end
            CMD_SET_FREQUENCY: begin
                o_reply.plen       = PLEN_FREQ;
                o_reply.payload[0] = n_freq[15:8];
                o_reply.payload[1] = n_freq[7:0];
            end
            CMD_SET_MODE: begin
                has_reply          = v2;
                o_reply.payload[0] = n_mode;
            end
            default: begin
                has_reply = 1'b0;
            end
        endcase
    end

    assign o_push = frame_ok && has_reply;

    // Frame-done latch: set by a good frame, cleared by the end of the buffer.
    always_comb begin
        n_done = r_done;
        if (frame_ok) begin
            n_done = 1'b1;
        end
        if (i_accept && i_beat.buffer_end) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_cmd     <= '0;
            r_left    <= '0;
            r_index   <= '0;
            r_crc     <= '0;
            r_held0   <= '0;
            r_held1   <= '0;
            r_power   <= POWER_RESET;
            r_channel <= CHANNEL_RESET;
            r_mode    <= MODE_RESET;
            r_freq    <= FREQ_RESET;
            r_done    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_left    <= n_left;
            r_index   <= n_index;
            r_crc     <= n_crc;
            r_held0   <= n_held0;
            r_held1   <= n_held1;
            r_power   <= n_power;
            r_channel <= n_channel;
            r_mode    <= n_mode;
            r_freq    <= n_freq;
            r_done    <= n_done;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/vcfr_queue.sv =====
`default_nettype none
module vcfr_queue
    import vcfr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_reply i_reply,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_reply      o_reply
);

    // Two reply entries between the parser and the emitter.
    t_reply     r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_reply = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_reply;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/vcfr_back.sv =====
`default_nettype none
module vcfr_back
    import vcfr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  wire t_reply i_reply,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output t_tx_beat    o_out
);

    logic       r_busy, n_busy;
    logic [3:0] r_idx, n_idx;
    logic [7:0] r_crc, n_crc;
    t_reply     r_reply, n_reply;
    logic       r_valid, n_valid;
    t_tx_beat   r_out, n_out;

    logic       advance;
    logic [3:0] crc_pos;
    logic [3:0] last_pos;
    logic [3:0] pay_off;
    logic [7:0] cur_byte;

    // The output register moves on when empty or when its beat is taken.
    assign advance  = !r_valid || !i_out_stall;
    assign crc_pos  = 4'd5 + {1'b0, r_reply.plen};
    assign last_pos = 4'd6 + {1'b0, r_reply.plen};
    assign pay_off  = r_idx - 4'd5;
    assign o_pop    = !r_busy && !i_empty;

    // Byte at the current position of the response frame.
    always_comb begin
        case (r_idx)
            4'd0:    cur_byte = PAD_BYTE;
            4'd1:    cur_byte = SYNC_BYTE1;
            4'd2:    cur_byte = SYNC_BYTE2;
            4'd3:    cur_byte = r_reply.code;
            4'd4:    cur_byte = {5'd0, r_reply.plen} + 8'd1;
            default: begin
                if (r_idx < crc_pos) begin
                    cur_byte = r_reply.payload[pay_off[2:0]];
                end else if (r_idx == crc_pos) begin
                    cur_byte = r_crc;
                end else begin
                    cur_byte = PAD_BYTE;
                end
            end
        endcase
    end

    // Emitter sequencing: load a reply, then walk its bytes.
    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_reply = r_reply;
        n_valid = r_valid;
        n_out   = r_out;
        if (advance) begin
            n_valid = 1'b0;
        end
        if (!r_busy) begin
            if (!i_empty) begin
                n_busy  = 1'b1;
                n_idx   = 4'd0;
                n_crc   = 8'd0;
                n_reply = i_reply;
            end
        end else if (advance) begin
            n_valid          = 1'b1;
            n_out.tx_byte    = cur_byte;
            n_out.frame_last = (r_idx == last_pos);
            if (r_idx >= 4'd3 && r_idx < crc_pos) begin
                n_crc = crc8_update(r_crc, cur_byte);
            end
            n_idx = r_idx + 4'd1;
            if (r_idx == last_pos) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_crc   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reply <= n_reply;
        r_out   <= n_out;
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== hdl/vtx_control_frame_responder.sv =====
// Control frame responder for a video transmitter. Received bytes arrive one
// beat per cycle unless the input is stalled, and are parsed in the cycle
// they are taken; a frame whose CRC checks updates the settings and queues
// a reply. Replies leave one byte per cycle while the output is not stalled,
// through a registered output, with an idle gap between frames while the
// emitter loads the next reply from its two-entry queue. The input is
// stalled only while both queue entries hold replies not yet started; a
// reply is at most twelve bytes and a request frame at least five. The
// protocol version register at address 0 selects version 2 when written with 2.
`default_nettype none
module vtx_control_frame_responder
    import vcfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_rx_beat           i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_tx_beat                o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [1:0] r_version;
    logic       in_accept;
    logic       push;
    t_reply     push_reply;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_reply     q_reply;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_VERSION) ? {30'd0, r_version} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VERSION_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_VERSION) begin
            r_version <= pwdata[1:0];
        end
    end

    // Input beats are held off while the reply queue is full.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    vcfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_beat    (i_in),
        .i_version (r_version),
        .o_push    (push),
        .o_reply   (push_reply)
    );

    vcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_reply (push_reply),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_reply (q_reply)
    );

    vcfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_reply     (q_reply),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ===== hdl/vcfr_checker.sv =====
`default_nettype none
module vcfr_checker
    import vcfr_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_in_stall,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_tx_beat o_out,
    input wire logic     pready
);

    // Nothing is offered and nothing is held off right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output beat changed");

    // Every response frame ends on the trailing pad byte.
    a_last_is_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.frame_last |-> o_out.tx_byte == PAD_BYTE)
        else $error("last byte of a reply is not the pad byte");

    // The register port never waits.
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind vtx_control_frame_responder vcfr_checker u_vcfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out),
    .pready      (pready)
);
`default_nettype wire
